// ===== rtl/i2crs_pkg.sv =====
// Package for the I2C register slave: phase and FSM types, event codes, constants.
// No dependencies.
package i2crs_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [6:0] OWN_ADDRESS_RST = 7'd69;
    localparam logic [1:0] POINTER_BYTES_RST = 2'd1;

    localparam logic [1:0] REQ_SCL_RISE = 2'd0;
    localparam logic [1:0] REQ_SCL_FALL = 2'd1;
    localparam logic [1:0] REQ_SDA_FALL = 2'd2;
    localparam logic [1:0] REQ_SDA_RISE = 2'd3;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic CFG_OWN_ADDRESS   = 1'b0;
    localparam logic CFG_POINTER_BYTES = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DEVADDR, PH_REGADDR, PH_DATA, PH_SEND
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_OUT
    } t_fsm;

endpackage

// ===== rtl/i2c_register_slave.sv =====
// Top level of the I2C register slave: bus protocol decode plus table search.
// Depends on i2crs_pkg.
//
// A bus edge item that touches no table entry needs no table scan. A data
// byte write or the first falling SCL edge of a read byte scans the table
// memory one entry per cycle, up to entries_used (at most TABLE_ENTRIES)
// entries and stopping at a hit, then passes through S_WAIT and S_OUT.
// One item is worked on at a time; a result waits in an output register and
// the next item is taken when it has been delivered.
module i2c_register_slave #(
    parameter int TABLE_ENTRIES = i2crs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_sda_pull_low,
    output logic       o_busy_res,
    output logic [1:0] o_store_status
);
    import i2crs_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    logic [15:0] mem_addr [TABLE_ENTRIES];
    logic [7:0]  mem_data [TABLE_ENTRIES];

    logic [6:0]  r_own_address;
    logic [1:0]  r_pointer_bytes;
    t_phase      r_phase, n_phase;
    t_fsm        r_fsm, n_fsm;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [3:0]  r_send_bit_count, n_send_bit_count;
    logic [7:0]  r_shift_byte, n_shift_byte;
    logic        r_is_read, n_is_read;
    logic        r_ack_pending, n_ack_pending;
    logic        r_drive_low, n_drive_low;
    logic [1:0]  r_pointer_byte_count, n_pointer_byte_count;
    logic [15:0] r_reg_pointer, n_reg_pointer;
    logic [15:0] r_write_offset, n_write_offset;
    logic [15:0] r_read_offset, n_read_offset;
    logic [CW-1:0] r_entries_used, n_entries_used;
    logic [1:0]  r_status, n_status;
    logic        r_out_valid;
    // search state
    logic        r_scan_wr;        // scan serves a write (else a read)
    logic [15:0] r_key;
    logic [7:0]  r_wdata;
    logic [CW-1:0] r_scan_idx;
    logic        r_rd_pend;        // a read was issued last cycle
    logic [15:0] r_rd_addr;
    logic [7:0]  r_rd_data;

    logic        accept;
    logic        scan_go;          // item needs a table scan
    logic        scan_wr_go;
    logic [15:0] key_go;
    logic        hit;
    logic        scan_end;
    logic        mem_we;
    logic [IW-1:0] mem_wi;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_fsm == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_sda_pull_low = r_drive_low;
    assign o_busy_res     = (r_phase != PH_IDLE);
    assign o_store_status = r_status;

    assign hit      = r_rd_pend && (r_rd_addr == r_key);
    assign scan_end = (r_scan_idx == r_entries_used);

    // Protocol step for one item; table work is deferred to the scan.
    always_comb begin
        n_phase = r_phase;
        n_bit_count = r_bit_count;
        n_send_bit_count = r_send_bit_count;
        n_shift_byte = r_shift_byte;
        n_is_read = r_is_read;
        n_ack_pending = r_ack_pending;
        n_drive_low = r_drive_low;
        n_pointer_byte_count = r_pointer_byte_count;
        n_reg_pointer = r_reg_pointer;
        n_write_offset = r_write_offset;
        n_read_offset = r_read_offset;
        scan_go = 1'b0;
        scan_wr_go = 1'b0;
        key_go = 16'd0;
        case (i_req_type)
            REQ_SCL_RISE: begin
                case (r_phase)
                    PH_DEVADDR: begin
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count != 4'd9)
                            n_shift_byte = {r_shift_byte[6:0], i_sda_level};
                        if (n_bit_count == 4'd8) begin
                            if (n_shift_byte[7:1] != r_own_address) begin
                                n_phase = PH_IDLE;
                                n_bit_count = 4'd0;
                                n_send_bit_count = 4'd0;
                            end else begin
                                n_is_read = n_shift_byte[0];
                                n_ack_pending = 1'b1;
                            end
                        end else if (n_bit_count >= 4'd9) begin
                            if (r_is_read) begin
                                n_read_offset = 16'd0;
                                n_phase = PH_SEND;
                            end else begin
                                n_pointer_byte_count = 2'd0;
                                n_phase = PH_REGADDR;
                            end
                            n_bit_count = 4'd0;
                            n_send_bit_count = 4'd0;
                        end
                    end
                    PH_REGADDR: begin
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count < 4'd9) begin
                            n_shift_byte = {r_shift_byte[6:0], i_sda_level};
                            if (n_bit_count == 4'd8) n_ack_pending = 1'b1;
                        end else begin
                            if (r_pointer_byte_count == 2'd0)
                                n_reg_pointer = {8'd0, r_shift_byte};
                            else
                                n_reg_pointer = {r_reg_pointer[7:0], r_shift_byte};
                            n_pointer_byte_count = r_pointer_byte_count + 2'd1;
                            n_bit_count = 4'd0;
                            if (n_pointer_byte_count >=
                                ((r_pointer_bytes == 2'd1) ? 2'd1 : 2'd2)) begin
                                n_phase = PH_DATA;
                                n_write_offset = 16'd0;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count < 4'd9) begin
                            n_shift_byte = {r_shift_byte[6:0], i_sda_level};
                            if (n_bit_count == 4'd8) n_ack_pending = 1'b1;
                        end else begin
                            scan_go = 1'b1;
                            scan_wr_go = 1'b1;
                            key_go = r_reg_pointer + r_write_offset;
                            n_write_offset = r_write_offset + 16'd1;
                            n_bit_count = 4'd0;
                        end
                    end
                    PH_SEND: begin
                        if (r_send_bit_count == 4'd0 && i_sda_level) begin
                            n_phase = PH_IDLE;
                            n_bit_count = 4'd0;
                            n_send_bit_count = 4'd0;
                            n_shift_byte = 8'd0;
                            n_ack_pending = 1'b0;
                            n_drive_low = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_SCL_FALL: begin
                if (r_phase == PH_SEND) begin
                    n_send_bit_count = r_send_bit_count + 4'd1;
                    n_ack_pending = 1'b0;
                    if (n_send_bit_count == 4'd1) begin
                        // Byte fetch: the scan finishes the first bit.
                        scan_go = 1'b1;
                        key_go = r_reg_pointer + r_read_offset;
                        n_read_offset = r_read_offset + 16'd1;
                    end else if (n_send_bit_count <= 4'd8) begin
                        n_drive_low = !r_shift_byte[7];
                        n_shift_byte = {r_shift_byte[6:0], 1'b0};
                    end else begin
                        n_send_bit_count = 4'd0;
                        n_drive_low = 1'b0;
                    end
                end else begin
                    if (r_drive_low && !r_ack_pending) n_drive_low = 1'b0;
                    if (r_ack_pending) begin
                        n_drive_low = 1'b1;
                        n_ack_pending = 1'b0;
                    end
                end
            end
            default: begin
                if (i_scl_level) begin
                    n_phase = (i_req_type == REQ_SDA_FALL) ? PH_DEVADDR : PH_IDLE;
                    n_bit_count = 4'd0;
                    n_send_bit_count = 4'd0;
                    n_shift_byte = 8'd0;
                    n_ack_pending = 1'b0;
                    n_drive_low = 1'b0;
                    if (i_req_type == REQ_SDA_RISE) n_read_offset = 16'd0;
                end
            end
        endcase
    end

    // Search sequencer next state.
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE: if (accept && scan_go) n_fsm = S_SCAN;
            S_SCAN: if (hit || scan_end) n_fsm = S_WAIT;
            S_WAIT: n_fsm = S_OUT;
            S_OUT:  n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    // Search sequencer outputs: memory write and status.
    always_comb begin
        mem_we = 1'b0;
        mem_wi = r_scan_idx[IW-1:0];
        n_status = ST_NONE;
        n_entries_used = r_entries_used;
        if (r_fsm == S_SCAN && r_scan_wr) begin
            if (hit) begin
                mem_we = 1'b1;
                mem_wi = IW'(r_scan_idx - CW'(1));
                n_status = ST_STORED;
            end else if (scan_end) begin
                if (r_entries_used != FULL_COUNT) begin
                    mem_we = 1'b1;
                    mem_wi = r_entries_used[IW-1:0];
                    n_entries_used = r_entries_used + CW'(1);
                    n_status = ST_STORED;
                end else begin
                    n_status = ST_FULL;
                end
            end
        end
    end

    // Table memory: one read and one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_addr[mem_wi] <= r_key;
            mem_data[mem_wi] <= r_wdata;
        end
        if (r_fsm == S_SCAN && !scan_end) begin
            r_rd_addr <= mem_addr[r_scan_idx[IW-1:0]];
            r_rd_data <= mem_data[r_scan_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDRESS_RST;
            r_pointer_bytes <= POINTER_BYTES_RST;
            r_phase <= PH_IDLE;
            r_fsm <= S_IDLE;
            r_bit_count <= 4'd0;
            r_send_bit_count <= 4'd0;
            r_shift_byte <= 8'd0;
            r_is_read <= 1'b0;
            r_ack_pending <= 1'b0;
            r_drive_low <= 1'b0;
            r_pointer_byte_count <= 2'd0;
            r_reg_pointer <= 16'd0;
            r_write_offset <= 16'd0;
            r_read_offset <= 16'd0;
            r_entries_used <= '0;
            r_status <= ST_NONE;
            r_out_valid <= 1'b0;
            r_rd_pend <= 1'b0;
            r_scan_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OWN_ADDRESS) r_own_address <= i_cfg_data;
                else r_pointer_bytes <= i_cfg_data[1:0];
            end
            r_fsm <= n_fsm;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            if (accept) begin
                r_phase <= n_phase;
                r_bit_count <= n_bit_count;
                r_send_bit_count <= n_send_bit_count;
                r_shift_byte <= n_shift_byte;
                r_is_read <= n_is_read;
                r_ack_pending <= n_ack_pending;
                r_drive_low <= n_drive_low;
                r_pointer_byte_count <= n_pointer_byte_count;
                r_reg_pointer <= n_reg_pointer;
                r_write_offset <= n_write_offset;
                r_read_offset <= n_read_offset;
                r_status <= ST_NONE;
                r_scan_wr <= scan_wr_go;
                r_key <= key_go;
                r_wdata <= n_shift_byte;
                r_scan_idx <= '0;
                r_rd_pend <= 1'b0;
                if (!scan_go) r_out_valid <= 1'b1;
            end
            if (r_fsm == S_SCAN) begin
                r_rd_pend <= !scan_end && !hit;
                if (!scan_end) r_scan_idx <= r_scan_idx + CW'(1);
                r_entries_used <= n_entries_used;
                if (hit || scan_end) begin
                    r_status <= n_status;
                    if (!r_scan_wr) begin
                        // First bit of the fetched byte goes out now.
                        r_drive_low <= hit ? !r_rd_data[7] : 1'b1;
                        r_shift_byte <= hit ? {r_rd_data[6:0], 1'b0} : 8'd0;
                    end
                end
            end
            if (r_fsm == S_OUT) r_out_valid <= 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries_used <= FULL_COUNT)
        else $error("entry count beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != S_IDLE) |-> !r_out_valid)
        else $error("result shown while table scan runs");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_fsm == S_SCAN && r_scan_wr))
        else $error("table written outside a write scan");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_SCAN) |-> (r_scan_idx <= r_entries_used))
        else $error("scan index past used entries");
endmodule

// ===== tb/sv/i2c_register_slave_checker.sv =====
// Checker for the I2C register slave: watches both channels, predicts each result item
// from its own model of the bus protocol and register table, and counts mismatches.
// Depends on i2crs_pkg.
module i2c_register_slave_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_req_type,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_sda_pull_low,
    input  logic       i_busy_res,
    input  logic [1:0] i_store_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2crs_pkg::*;

    localparam int ENTRIES = TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic       pull_low;
        logic       busy;
        logic [1:0] status;
    } t_bus_result;

    t_bus_result expected_results[$];

    logic [6:0]  own_addr;
    logic [1:0]  ptr_bytes_cfg;
    t_phase      phase;
    logic [3:0]  bit_cnt;
    logic [3:0]  send_cnt;
    logic [7:0]  shreg;
    logic        rd_xfer;
    logic        ack_pend;
    logic        pull;
    logic [1:0]  ptr_cnt;
    logic [15:0] reg_ptr;
    logic [15:0] wr_off;
    logic [15:0] rd_off;
    logic [15:0] tab_addr [ENTRIES];
    logic [7:0]  tab_data [ENTRIES];
    int          used;

    function automatic logic [7:0] table_fetch(logic [15:0] a);
        for (int i = 0; i < used; i++)
            if (tab_addr[i] == a) return tab_data[i];
        return 8'h00;
    endfunction

    function automatic logic [1:0] table_store(input logic [15:0] a, input logic [7:0] d);
        for (int i = 0; i < used; i++) begin
            if (tab_addr[i] == a) begin
                tab_data[i] = d;
                return ST_STORED;
            end
        end
        if (used < ENTRIES) begin
            tab_addr[used] = a;
            tab_data[used] = d;
            used++;
            return ST_STORED;
        end
        return ST_FULL;
    endfunction

    function automatic void clear_bits();
        bit_cnt = 0;
        send_cnt = 0;
        shreg = 0;
        ack_pend = 0;
        pull = 0;
    endfunction

    function automatic logic [1:0] on_scl_rise(input logic sda);
        logic [1:0] st;
        st = ST_NONE;
        case (phase)
            PH_DEVADDR: begin
                bit_cnt++;
                if (bit_cnt != 9) shreg = {shreg[6:0], sda};
                if (bit_cnt == 8) begin
                    if (shreg[7:1] != own_addr) begin
                        phase = PH_IDLE;
                        bit_cnt = 0;
                        send_cnt = 0;
                    end else begin
                        rd_xfer = shreg[0];
                        ack_pend = 1;
                    end
                end else if (bit_cnt >= 9) begin
                    if (rd_xfer) begin
                        rd_off = 0;
                        phase = PH_SEND;
                    end else begin
                        ptr_cnt = 0;
                        phase = PH_REGADDR;
                    end
                    bit_cnt = 0;
                    send_cnt = 0;
                end
            end
            PH_REGADDR: begin
                bit_cnt++;
                if (bit_cnt < 9) begin
                    shreg = {shreg[6:0], sda};
                    if (bit_cnt == 8) ack_pend = 1;
                end else begin
                    if (ptr_cnt == 0) reg_ptr = {8'h00, shreg};
                    else reg_ptr = {reg_ptr[7:0], shreg};
                    ptr_cnt++;
                    bit_cnt = 0;
                    if (ptr_cnt >= ((ptr_bytes_cfg == 2'd1) ? 2'd1 : 2'd2)) begin
                        phase = PH_DATA;
                        wr_off = 0;
                    end
                end
            end
            PH_DATA: begin
                bit_cnt++;
                if (bit_cnt < 9) begin
                    shreg = {shreg[6:0], sda};
                    if (bit_cnt == 8) ack_pend = 1;
                end else begin
                    st = table_store(reg_ptr + wr_off, shreg);
                    wr_off = wr_off + 16'd1;
                    bit_cnt = 0;
                end
            end
            PH_SEND: begin
                // A released data line in the acknowledge slot is the master's NACK.
                if (send_cnt == 0 && sda) begin
                    phase = PH_IDLE;
                    clear_bits();
                end
            end
            default: ;
        endcase
        return st;
    endfunction

    function automatic void on_scl_fall();
        if (phase == PH_SEND) begin
            send_cnt++;
            if (send_cnt == 1) begin
                shreg = table_fetch(reg_ptr + rd_off);
                rd_off = rd_off + 16'd1;
            end
            if (send_cnt <= 8) begin
                pull = !shreg[7];
                shreg = {shreg[6:0], 1'b0};
            end else begin
                send_cnt = 0;
                pull = 0;
            end
            ack_pend = 0;
        end else begin
            if (pull && !ack_pend) pull = 0;
            if (ack_pend) begin
                pull = 1;
                ack_pend = 0;
            end
        end
    endfunction

    function automatic t_bus_result predict_edge(logic [1:0] req, logic scl, logic sda);
        t_bus_result r;
        logic [1:0] st;
        st = ST_NONE;
        case (req)
            REQ_SCL_RISE: st = on_scl_rise(sda);
            REQ_SCL_FALL: on_scl_fall();
            REQ_SDA_FALL: begin
                if (scl) begin
                    phase = PH_DEVADDR;
                    clear_bits();
                end
            end
            default: begin
                if (scl) begin
                    phase = PH_IDLE;
                    clear_bits();
                    rd_off = 0;
                end
            end
        endcase
        r.pull_low = pull;
        r.busy = (phase != PH_IDLE);
        r.status = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bus_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            own_addr = OWN_ADDRESS_RST;
            ptr_bytes_cfg = POINTER_BYTES_RST;
            phase = PH_IDLE;
            clear_bits();
            rd_xfer = 0;
            ptr_cnt = 0;
            reg_ptr = 0;
            wr_off = 0;
            rd_off = 0;
            used = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OWN_ADDRESS) own_addr = i_cfg_data;
                else ptr_bytes_cfg = i_cfg_data[1:0];
            end
            // The result leaving now always belongs to an older item, so pop first.
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_sda_pull_low !== want.pull_low) begin
                        $error("sda_pull_low: expected %0d, actual %0d",
                               want.pull_low, i_sda_pull_low);
                        o_fail_count++;
                    end
                    if (i_busy_res !== want.busy) begin
                        $error("busy_res: expected %0d, actual %0d", want.busy, i_busy_res);
                        o_fail_count++;
                    end
                    if (i_store_status !== want.status) begin
                        $error("store_status: expected %0d, actual %0d",
                               want.status, i_store_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_edge(i_req_type, i_scl_level, i_sda_level));
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

endmodule

// ===== tb/sv/i2c_register_slave_tb.sv =====
// Top of the I2C register slave testbench: clock, reset, bus transfer stimulus,
// register settings and verdict. Depends on i2crs_pkg and i2c_register_slave_checker.
module i2c_register_slave_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2crs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET = 1700;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [6:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_req_type = '0;
    logic       i_scl_level = 1'b0;
    logic       i_sda_level = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_sda_pull_low;
    logic       o_busy_res;
    logic [1:0] o_store_status;

    int  fail_count, pending, checked;
    int  items_sent = 0;
    int  settings_done = 0;
    int  stall_cycles = 0;
    bit  no_idle = 0;
    bit  hold_request = 0;
    bit  hold_issued = 0;
    logic [6:0] cur_own = OWN_ADDRESS_RST;
    logic [1:0] cur_ptr_bytes = POINTER_BYTES_RST;

    i2c_register_slave dut (.*);

    i2c_register_slave_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_req_type, .i_scl_level, .i_sda_level,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_sda_pull_low(o_sda_pull_low), .i_busy_res(o_busy_res),
        .i_store_status(o_store_status),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Alternate between stretches with random gaps and stretches with none.
    initial begin
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge i_clk);
            no_idle = !no_idle;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("i2c_register_slave test failed");
            $finish;
        end
    end

    // Receiver: a random wait before each result item, and one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_edge(input logic [1:0] req, input logic scl, input logic sda);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_scl_level <= scl;
        i_sda_level <= sda;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (!hold_issued && items_sent >= 600) begin
            hold_issued = 1;
            hold_request = 1;
        end
    endtask

    task automatic bus_start();
        send_edge(REQ_SDA_FALL, 1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        send_edge(REQ_SDA_RISE, 1'b1, 1'b1);
    endtask

    task automatic clock_bit(input logic b);
        send_edge(REQ_SCL_RISE, 1'b1, b);
        send_edge(REQ_SCL_FALL, 1'b0, b);
    endtask

    // Eight data bits MSB first and the acknowledge clock.
    task automatic write_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) clock_bit(b[i]);
        clock_bit(1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_pointer();
        // Mostly a few low addresses so that writes hit stored entries again.
        case ($urandom_range(0, 19))
            0: return 16'hFFFF;
            1: return 16'hFFFE;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [6:0] pick_address();
        return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : cur_own;
    endfunction

    task automatic read_transfer();
        int n;
        logic last;
        n = $urandom_range(1, 4);
        bus_start();
        write_byte({pick_address(), 1'b1});
        for (int k = 0; k < n; k++) begin
            repeat (8) begin
                send_edge(REQ_SCL_RISE, 1'b1, 1'($urandom_range(0, 1)));
                send_edge(REQ_SCL_FALL, 1'b0, 1'($urandom_range(0, 1)));
            end
            last = (k == n - 1);
            // The master answers NACK on the last byte, now and then ACK instead.
            send_edge(REQ_SCL_RISE, 1'b1, last && ($urandom_range(0, 7) != 0));
            if (!last) send_edge(REQ_SCL_FALL, 1'b0, 1'b0);
        end
        bus_stop();
    endtask

    task automatic write_transfer();
        logic [15:0] ptr;
        int nptr, ndata;
        ptr = pick_pointer();
        nptr = (cur_ptr_bytes == 2'd1) ? 1 : 2;
        if ($urandom_range(0, 9) == 0) nptr = nptr - 1;
        ndata = $urandom_range(0, 5);
        bus_start();
        write_byte({pick_address(), 1'b0});
        if (nptr == 2) write_byte(ptr[15:8]);
        if (nptr >= 1) write_byte(ptr[7:0]);
        repeat (ndata) write_byte(pick_byte());
        // A repeated start straight into a read keeps the pointer just set.
        if ($urandom_range(0, 3) == 0) read_transfer();
        else bus_stop();
    endtask

    task automatic line_noise();
        repeat ($urandom_range(1, 12))
            send_edge(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic apply_setting(input logic [6:0] own, input logic [1:0] pb);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_OWN_ADDRESS;
        i_cfg_data <= own;
        @(posedge i_clk);
        i_cfg_index <= CFG_POINTER_BYTES;
        i_cfg_data <= {5'b0, pb};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_own = own;
        cur_ptr_bytes = pb;
        settings_done++;
    endtask

    initial begin
        logic [6:0] own_list [6];
        logic [1:0] pb_list [6];
        int wait_cycles;
        int sel;
        own_list = '{7'd69, 7'd0, 7'd127, 7'd42, 7'd85, 7'd69};
        pb_list = '{2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clock edges while idle, data edges with the clock low,
        // a foreign address, the extremes of pointer and data, then a read back.
        send_edge(REQ_SCL_RISE, 1'b1, 1'b1);
        send_edge(REQ_SCL_FALL, 1'b0, 1'b0);
        send_edge(REQ_SDA_FALL, 1'b0, 1'b0);
        send_edge(REQ_SDA_RISE, 1'b0, 1'b1);
        bus_start();
        write_byte({7'h7F, 1'b0});
        bus_stop();
        bus_start();
        write_byte({cur_own, 1'b0});
        write_byte(8'hFF);
        write_byte(8'h00);
        write_byte(8'hFF);
        bus_start();
        write_byte({cur_own, 1'b1});
        send_edge(REQ_SCL_FALL, 1'b0, 1'b0);
        bus_stop();

        for (int p = 0; p < 6; p++) begin
            apply_setting(own_list[p], pb_list[p]);
            while (items_sent < (p + 1) * ITEM_TARGET / 6) begin
                sel = $urandom_range(0, 19);
                if (sel < 3) line_noise();
                else if (sel < 12) write_transfer();
                else read_transfer();
            end
        end

        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run drove %0d bus edge items over %0d register settings; %0d results checked.",
                 items_sent, settings_done, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("i2c_register_slave test passed");
        end else begin
            if (pending != 0) $error("%0d expected result items never arrived", pending);
            $display("i2c_register_slave test failed");
        end
        $finish;
    end

endmodule
